>>> rtl/rxd_pkg.sv
// Shared types and constants for the row XOR delta filter.
package rxd_pkg;

    localparam int DATA_W                  = 32;
    localparam int CFG_W                   = 9;
    localparam int LINE_DEPTH              = 256;
    localparam int COL_W                   = $clog2(LINE_DEPTH);
    localparam int DEFAULT_MAX_CHUNK_WORDS = 256;
    localparam int ADDR_W                  = 4;

    typedef enum logic [1:0] {
        REG_ROW_WORDS   = 2'd0,
        REG_CHUNK_WORDS = 2'd1,
        REG_DECODE_MODE = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic             busy;
        logic [CFG_W-1:0] whole;
    } div_stat_t;

endpackage

>>> rtl/rxd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rxd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/rxd_div.sv
// Bit-serial unit giving the length of the complete-row part of a chunk.
module rxd_div
    import rxd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CFG_W-1:0] dividend,
    input  logic [CFG_W-1:0] divisor,
    output div_stat_t        stat
);

    localparam int STEP_W = $clog2(CFG_W + 1);

    logic              run_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CFG_W-1:0]  dvd_reg;
    logic [CFG_W-1:0]  num_reg;
    logic [CFG_W-1:0]  den_reg;
    logic [CFG_W-1:0]  rem_reg;
    logic [CFG_W-1:0]  whole_reg;

    logic [CFG_W:0]    trial;
    logic [CFG_W-1:0]  rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[CFG_W-1]};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = CFG_W'(trial - {1'b0, den_reg});
        end
        else
        begin
            rem_next = trial[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            step_reg <= STEP_W'(CFG_W);
        end
        else if (run_reg)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[CFG_W-2:0], 1'b0};
            rem_reg <= rem_next;
            if (step_reg == STEP_W'(1))
            begin
                whole_reg <= num_reg - rem_next;
            end
        end
    end

    assign stat.busy  = start | run_reg;
    assign stat.whole = whole_reg;

endmodule

>>> rtl/row_xor_delta_filter.sv
// Top level of the row XOR delta filter: config port, line store pipeline, output queue.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------
//  input   | in_valid/in_stall  | data_word
//  output  | out_valid/out_stall| filtered_word, chunk_end, chunk_all_zero
//  config  | APB psel/penable   | paddr, pwdata, prdata (pready tied high)
//
// One word per cycle while in_stall is low; an accepted word passes the stage 1 registers
// and the output queue before out_valid. The line store RAM is read on accept and written
// back in the cycle after; a same-column write in flight is forwarded.
// After reset and after a row_words or chunk_words write, in_stall is high while
// the serial unit computes the complete-row length.
// A four-word output queue takes up to three words while the output is stalled.
module row_xor_delta_filter
    import rxd_pkg::*;
#(
    parameter int MAX_CHUNK_WORDS = DEFAULT_MAX_CHUNK_WORDS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [DATA_W-1:0] data_word,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] filtered_word,
    output logic              chunk_end,
    output logic              chunk_all_zero
);

    localparam int             CAP_I     = (MAX_CHUNK_WORDS > (2**CFG_W - 1)) ?
                                           (2**CFG_W - 1) : MAX_CHUNK_WORDS;
    localparam logic [CFG_W-1:0] CHUNK_CAP = CAP_I[CFG_W-1:0];
    localparam logic [CFG_W-1:0] ROW_CAP   = CFG_W'(LINE_DEPTH);
    localparam int             Q_DEPTH   = 4;
    localparam int             Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int             Q_CNT_W   = Q_PTR_W + 1;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_FIRST,
        KIND_XOR
    } kind_t;

    typedef struct packed {
        logic [DATA_W-1:0] word;
        logic              last;
        logic              zero;
    } out_word_t;

    // configuration
    logic [CFG_W-1:0] row_words_reg;
    logic [CFG_W-1:0] chunk_words_reg;
    logic             decode_mode_reg;
    logic             start_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    logic [CFG_W-1:0] eff_row;
    logic [CFG_W-1:0] eff_chunk;
    div_stat_t        div_stat;

    // stage 0 state
    logic [COL_W-1:0] column_index_reg;
    logic [CFG_W-1:0] word_index_reg;
    logic             row_is_complete_reg;
    logic             zero_so_far_reg;

    logic             accept;
    logic             is_tail;
    logic             is_last;
    logic             col_wrap;
    logic             zero_next;
    kind_t            kind_next;

    // stage 1
    logic              s1_valid_reg;
    logic [DATA_W-1:0] s1_word_reg;
    logic [COL_W-1:0]  s1_col_reg;
    kind_t             s1_kind_reg;
    logic              s1_last_reg;
    logic              s1_zero_reg;
    logic              s1_decode_reg;
    logic              fwd_valid_reg;
    logic [DATA_W-1:0] fwd_data_reg;

    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] above;
    logic [DATA_W-1:0] result;
    logic              ram_we;
    logic [DATA_W-1:0] ram_wdata;

    // output queue
    out_word_t          q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] q_wr_reg;
    logic [Q_PTR_W-1:0] q_rd_reg;
    logic [Q_CNT_W-1:0] q_cnt_reg;
    logic [Q_CNT_W-1:0] q_cnt_next;
    logic [Q_CNT_W-1:0] q_load;
    logic               q_pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        case (cfg_idx)
            REG_ROW_WORDS:   prdata = {{(32-CFG_W){1'b0}}, row_words_reg};
            REG_CHUNK_WORDS: prdata = {{(32-CFG_W){1'b0}}, chunk_words_reg};
            REG_DECODE_MODE: prdata = {31'b0, decode_mode_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_words_reg   <= CFG_W'(1);
            chunk_words_reg <= CFG_W'(256);
            decode_mode_reg <= 1'b0;
            start_reg       <= 1'b1;
        end
        else
        begin
            start_reg <= cfg_wr &&
                         (cfg_idx == REG_ROW_WORDS || cfg_idx == REG_CHUNK_WORDS);
            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_ROW_WORDS:   row_words_reg   <= pwdata[CFG_W-1:0];
                    REG_CHUNK_WORDS: chunk_words_reg <= pwdata[CFG_W-1:0];
                    REG_DECODE_MODE: decode_mode_reg <= pwdata[0];
                    default:         ;
                endcase
            end
        end
    end

    always_comb
    begin
        if (row_words_reg == '0)
            eff_row = CFG_W'(1);
        else if (row_words_reg > ROW_CAP)
            eff_row = ROW_CAP;
        else
            eff_row = row_words_reg;

        if (chunk_words_reg == '0)
            eff_chunk = CFG_W'(1);
        else if (chunk_words_reg > CHUNK_CAP)
            eff_chunk = CHUNK_CAP;
        else
            eff_chunk = chunk_words_reg;
    end

    rxd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (eff_chunk),
        .divisor  (eff_row),
        .stat     (div_stat)
    );

    // stage 0: counters and line store read
    assign q_load   = q_cnt_reg + {{(Q_CNT_W-1){1'b0}}, s1_valid_reg};
    assign in_stall = div_stat.busy || (q_load > Q_CNT_W'(Q_DEPTH - 2));
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        is_tail   = word_index_reg >= div_stat.whole;
        is_last   = ({1'b0, word_index_reg} + (CFG_W+1)'(1)) >= {1'b0, eff_chunk};
        col_wrap  = ({1'b0, column_index_reg} + (COL_W+1)'(1)) >= (COL_W+1)'(eff_row);
        zero_next = zero_so_far_reg && (data_word == '0);
        if (is_tail)
            kind_next = KIND_PASS;
        else if (!row_is_complete_reg)
            kind_next = KIND_FIRST;
        else
            kind_next = KIND_XOR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_index_reg    <= '0;
            word_index_reg      <= '0;
            row_is_complete_reg <= 1'b0;
            zero_so_far_reg     <= 1'b1;
        end
        else if (accept)
        begin
            if (is_last)
            begin
                column_index_reg    <= '0;
                word_index_reg      <= '0;
                row_is_complete_reg <= 1'b0;
                zero_so_far_reg     <= 1'b1;
            end
            else
            begin
                word_index_reg  <= word_index_reg + CFG_W'(1);
                zero_so_far_reg <= zero_next;
                if (col_wrap)
                begin
                    column_index_reg    <= '0;
                    row_is_complete_reg <= 1'b1;
                end
                else
                begin
                    column_index_reg <= column_index_reg + COL_W'(1);
                end
            end
        end
    end

    rxd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_col_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (column_index_reg),
        .rdata (ram_rdata)
    );

    // stage 1: XOR and write back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            fwd_valid_reg <= accept && ram_we && (s1_col_reg == column_index_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= ram_wdata;
        if (accept)
        begin
            s1_word_reg   <= data_word;
            s1_col_reg    <= column_index_reg;
            s1_kind_reg   <= kind_next;
            s1_last_reg   <= is_last;
            s1_zero_reg   <= is_last && zero_next;
            s1_decode_reg <= decode_mode_reg;
        end
    end

    always_comb
    begin
        above  = fwd_valid_reg ? fwd_data_reg : ram_rdata;
        result = (s1_kind_reg == KIND_XOR) ? (s1_word_reg ^ above) : s1_word_reg;
        ram_we = s1_valid_reg && (s1_kind_reg != KIND_PASS);
        ram_wdata = (s1_kind_reg == KIND_XOR && s1_decode_reg) ? result : s1_word_reg;
    end

    // output queue
    assign q_pop = out_valid && !out_stall;

    always_comb
    begin
        q_cnt_next = q_cnt_reg;
        if (s1_valid_reg && !q_pop)
            q_cnt_next = q_cnt_reg + Q_CNT_W'(1);
        else if (!s1_valid_reg && q_pop)
            q_cnt_next = q_cnt_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_next;
            if (s1_valid_reg)
                q_wr_reg <= q_wr_reg + Q_PTR_W'(1);
            if (q_pop)
                q_rd_reg <= q_rd_reg + Q_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            q_mem[q_wr_reg] <= '{word: result, last: s1_last_reg, zero: s1_zero_reg};
        end
    end

    assign out_valid      = (q_cnt_reg != '0);
    assign filtered_word  = q_mem[q_rd_reg].word;
    assign chunk_end      = q_mem[q_rd_reg].last;
    assign chunk_all_zero = q_mem[q_rd_reg].zero;

endmodule

>>> rtl/rxd_checker.sv
// Port-level assertions for the row XOR delta filter, bound to the top level.
module rxd_checker
    import rxd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic              pready,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [DATA_W-1:0] filtered_word,
    input logic              chunk_end,
    input logic              chunk_all_zero
);

    // accepted word reaches the output after the stage 1 registers and the queue write
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##2 out_valid)
        else $error("accepted word not delivered on time");

    // row or chunk length write holds off input while row length is recomputed
    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready &&
        (paddr[ADDR_W-1:2] == REG_ROW_WORDS || paddr[ADDR_W-1:2] == REG_CHUNK_WORDS)
        |=> in_stall)
        else $error("input accepted during row length update");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chunk_all_zero |-> chunk_end)
        else $error("all-zero flag outside chunk end");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(filtered_word) &&
        $stable(chunk_end) && $stable(chunk_all_zero))
        else $error("stalled output word changed");

endmodule

bind row_xor_delta_filter rxd_checker u_rxd_checker (.*);

>>> test/tb_top.sv
// Self-checking testbench for row_xor_delta_filter: directed and random chunks.
`timescale 1ns / 1ps

module tb_top;
    import rxd_pkg::*;

    localparam int CHUNK_LIMIT = DEFAULT_MAX_CHUNK_WORDS;

    typedef struct {
        logic [DATA_W-1:0] word;
        logic              last;
        logic              all_zero;
    } filter_word_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [DATA_W-1:0] data_word = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DATA_W-1:0] filtered_word;
    logic              chunk_end;
    logic              chunk_all_zero;

    // predictor state
    logic [CFG_W-1:0]  cfg_row = 9'd1;
    logic [CFG_W-1:0]  cfg_chunk = 9'd256;
    logic              cfg_decode = 1'b0;
    logic [DATA_W-1:0] row_above [LINE_DEPTH];
    logic [COL_W-1:0]  col_pos = '0;
    logic [CFG_W-1:0]  word_pos = '0;
    logic              row_done = 1'b0;
    logic              zero_run = 1'b1;

    filter_word_t expected_words [$];
    int           error_count = 0;
    int           words_sent = 0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;

    row_xor_delta_filter #(
        .MAX_CHUNK_WORDS(CHUNK_LIMIT)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_word      (data_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .filtered_word  (filtered_word),
        .chunk_end      (chunk_end),
        .chunk_all_zero (chunk_all_zero)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin : check_out
        filter_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: filtered_word %h", filtered_word);
                error_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (filtered_word !== want.word)
                begin
                    $error("filtered_word: expected %h, got %h", want.word, filtered_word);
                    error_count++;
                end
                if (chunk_end !== want.last)
                begin
                    $error("chunk_end: expected %b, got %b", want.last, chunk_end);
                    error_count++;
                end
                if (chunk_all_zero !== want.all_zero)
                begin
                    $error("chunk_all_zero: expected %b, got %b", want.all_zero,
                           chunk_all_zero);
                    error_count++;
                end
            end
        end
    end

    task automatic predict_filter(input logic [DATA_W-1:0] w);
        int unsigned  row_len;
        int unsigned  chunk_len;
        int unsigned  whole_len;
        int unsigned  col;
        filter_word_t r;
        row_len = (cfg_row == 0) ? 1 : ((cfg_row > LINE_DEPTH) ? LINE_DEPTH : cfg_row);
        chunk_len = (cfg_chunk == 0) ? 1 : ((cfg_chunk > CHUNK_LIMIT) ? CHUNK_LIMIT : cfg_chunk);
        whole_len = chunk_len - (chunk_len % row_len);
        col = col_pos;
        if (word_pos >= whole_len)
            r.word = w;
        else if (!row_done)
        begin
            r.word = w;
            row_above[col] = w;
        end
        else
        begin
            r.word = w ^ row_above[col];
            row_above[col] = cfg_decode ? r.word : w;
        end
        zero_run = zero_run && (w == '0);
        r.last = (word_pos + 1 >= chunk_len);
        r.all_zero = r.last && zero_run;
        if (r.last)
        begin
            col_pos = '0;
            word_pos = '0;
            row_done = 1'b0;
            zero_run = 1'b1;
        end
        else
        begin
            word_pos = word_pos + 9'd1;
            if (col + 1 >= row_len)
            begin
                col_pos = '0;
                row_done = 1'b1;
            end
            else
                col_pos = COL_W'(col + 1);
        end
        expected_words.push_back(r);
    endtask

    task automatic send_word(input logic [DATA_W-1:0] w);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_word <= w;
        do @(posedge clk); while (in_stall);
        predict_filter(w);
        words_sent++;
    endtask

    task automatic read_reg(input reg_idx_t idx);
        logic [CFG_W-1:0] want;
        logic [CFG_W-1:0] got;
        case (idx)
            REG_ROW_WORDS:   want = cfg_row;
            REG_CHUNK_WORDS: want = cfg_chunk;
            default:         want = {8'd0, cfg_decode};
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = (idx == REG_DECODE_MODE) ? {8'd0, prdata[0]} : prdata[CFG_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", idx.name(), want, got);
            error_count++;
        end
        @(posedge clk);
    endtask

    // Waits for the pipeline to drain, writes, then reads back.
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        logic [31:0] spare_bits;
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        spare_bits = ($urandom_range(3) == 0) ? $urandom : 32'd0;
        spare_bits &= (idx == REG_DECODE_MODE) ? 32'hFFFF_FFFE : 32'hFFFF_FE00;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {23'd0, value} | spare_bits;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_ROW_WORDS:   cfg_row = value;
            REG_CHUNK_WORDS: cfg_chunk = value;
            default:         cfg_decode = value[0];
        endcase
        read_reg(idx);
    endtask

    function automatic logic [DATA_W-1:0] random_pixel();
        int unsigned b;
        b = $urandom_range(31);
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1 << b;
            3:       return ~(32'd1 << b);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_size(input bit chunk_len);
        case ($urandom_range(31))
            0:       return 9'd0;
            1:       return $urandom_range(1) ? 9'd256 : 9'($urandom_range(257, 511));
            2:       return 9'($urandom_range(1, 256));
            default: return chunk_len ? 9'($urandom_range(2, 16)) : 9'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic tweak_reg();
        case ($urandom_range(2))
            0:       write_reg(REG_ROW_WORDS, random_size(1'b0));
            1:       write_reg(REG_CHUNK_WORDS, random_size(1'b1));
            default: write_reg(REG_DECODE_MODE, 9'($urandom_range(1)));
        endcase
    endtask

    task automatic test_reset_values();
        read_reg(REG_ROW_WORDS);
        read_reg(REG_CHUNK_WORDS);
        read_reg(REG_DECODE_MODE);
    endtask

    // Oversized settings clamp to 256; one full row writes every line store entry.
    task automatic test_line_store_fill();
        send_idle_pct = 21;
        stall_pct = 21;
        write_reg(REG_ROW_WORDS, 9'd300);
        write_reg(REG_CHUNK_WORDS, 9'd511);
        write_reg(REG_DECODE_MODE, 9'd0);
        repeat (256) send_word(random_pixel());
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    task automatic test_encode_rows_and_tail();
        write_reg(REG_ROW_WORDS, 9'd2);
        write_reg(REG_CHUNK_WORDS, 9'd5);
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0000);
        send_word(32'h8000_0001);
    endtask

    task automatic test_decode_chain();
        write_reg(REG_DECODE_MODE, 9'd1);
        write_reg(REG_CHUNK_WORDS, 9'd6);
        send_word(32'h1234_5678);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0F0F_0F0F);
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0001);
    endtask

    task automatic test_all_zero_flag();
        write_reg(REG_DECODE_MODE, 9'd0);
        write_reg(REG_ROW_WORDS, 9'd1);
        write_reg(REG_CHUNK_WORDS, 9'd2);
        send_word(32'h0);
        send_word(32'h0);
        send_word(32'h0);
        send_word(32'h8000_0000);
    endtask

    // zero row and chunk lengths act as one: every word is its own chunk
    task automatic test_zero_sizes();
        write_reg(REG_ROW_WORDS, 9'd0);
        write_reg(REG_CHUNK_WORDS, 9'd0);
        send_word(32'h0);
        send_word(32'hDEAD_BEEF);
    endtask

    task automatic test_midchunk_config();
        send_idle_pct = 21;
        stall_pct = 21;
        write_reg(REG_ROW_WORDS, 9'd4);
        write_reg(REG_CHUNK_WORDS, 9'd8);
        send_word(32'hA5A5_A5A5);
        send_word(32'h5A5A_5A5A);
        send_word(32'h0000_FFFF);
        // column already past the new width: row closes on the next word
        write_reg(REG_ROW_WORDS, 9'd2);
        send_word(32'hFFFF_0000);
        write_reg(REG_DECODE_MODE, 9'd1);
        send_word(32'h1357_9BDF);
        // word count already past the new length: chunk closes on the next word
        write_reg(REG_CHUNK_WORDS, 9'd3);
        send_word(32'h2468_ACE0);
        write_reg(REG_DECODE_MODE, 9'd0);
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    task automatic run_random_chunk();
        bit zeros;
        int split;
        repeat ($urandom_range(0, 2)) tweak_reg();
        zeros = ($urandom_range(5) == 0);
        split = ($urandom_range(7) == 0) ? $urandom_range(1, 12) : 0;
        do
        begin
            send_word(zeros ? 32'd0 : random_pixel());
            if (split > 0 && word_pos == split)
            begin
                tweak_reg();
                split = 0;
            end
        end
        while (word_pos != 0);
    endtask

    task automatic test_random_chunks();
        int target;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 52; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 52; end
                default: begin send_idle_pct = 21; stall_pct = 21; end
            endcase
            target = words_sent + 55;
            while (words_sent < target) run_random_chunk();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_line_store_fill();
        test_encode_rows_and_tail();
        test_decode_chain();
        test_all_zero_flag();
        test_zero_sizes();
        test_midchunk_config();
        test_random_chunks();
        in_valid <= 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
